// ===== sv/tcse_pkg.sv =====
// ---------------------------------------------------------------------------
// tcse_pkg: shared definitions for the text console scroll engine
// Field widths, character codes, function codes and sweep control types.
// ---------------------------------------------------------------------------
`default_nettype none

package tcse_pkg;

  // default screen geometry
  localparam int DEF_COLUMNS   = 80;
  localparam int DEF_ROW_COUNT = 25;

  // fixed field widths
  localparam int FUNC_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int CURSOR_W = 11;
  localparam int ATTR_W   = 8;
  localparam int CELL_W   = 16;

  localparam logic [ATTR_W-1:0] ATTR_RESET    = 8'd10;
  localparam logic [CHAR_W-1:0] KEY_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] BLANK_GLYPH   = 8'h20;

  // function codes of an input item
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // sweep counter control: step advances, wrap returns to zero
  typedef struct packed {
    logic step;
    logic wrap;
  } sweep_cmd_t;

  // sweep counter position flags
  typedef struct packed {
    logic copy_last;  // last destination cell of a scroll copy
    logic fill_last;  // last cell of the store
  } sweep_stat_t;

endpackage

`default_nettype wire

// ===== sv/tcse_cell_ram.sv =====
// ---------------------------------------------------------------------------
// tcse_cell_ram: character cell store
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module tcse_cell_ram #(
  parameter int DEPTH  = tcse_pkg::DEF_COLUMNS * tcse_pkg::DEF_ROW_COUNT,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [ADDR_W-1:0]           waddr,
  input  wire logic [tcse_pkg::CELL_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0]           raddr,
  output logic      [tcse_pkg::CELL_W-1:0] rdata
);
  import tcse_pkg::*;

  logic [CELL_W-1:0] cells [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= cells[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/tcse_sweep_unit.sv =====
// ---------------------------------------------------------------------------
// tcse_sweep_unit: shared address counter for clear, init and scroll sweeps
// Holds the sweep position, its increment, the one-row-down source address
// and the end compares.
// ---------------------------------------------------------------------------
`default_nettype none

module tcse_sweep_unit #(
  parameter int COLUMNS   = tcse_pkg::DEF_COLUMNS,
  parameter int ROW_COUNT = tcse_pkg::DEF_ROW_COUNT,
  parameter int ADDR_W    = $clog2(COLUMNS * ROW_COUNT)
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire tcse_pkg::sweep_cmd_t    cmd,
  output logic [ADDR_W-1:0]            cnt,
  output logic [ADDR_W-1:0]            src_addr,
  output tcse_pkg::sweep_stat_t        stat
);
  import tcse_pkg::*;

  localparam int CELL_TOTAL = COLUMNS * ROW_COUNT;

  logic [ADDR_W-1:0] cnt_next;

  always_comb begin
    cnt_next = cnt;
    if (cmd.step) begin
      cnt_next = cmd.wrap ? '0 : cnt + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // scroll copy source is one row below the destination
  assign src_addr       = cnt + ADDR_W'(COLUMNS);
  assign stat.copy_last = (cnt == ADDR_W'(CELL_TOTAL - COLUMNS - 1));
  assign stat.fill_last = (cnt == ADDR_W'(CELL_TOTAL - 1));

endmodule

`default_nettype wire

// ===== sv/text_console_scroll_engine.sv =====
// ---------------------------------------------------------------------------
// text_console_scroll_engine: text console with cursor and one-line scroll
// Cell store, text cursor, hardware cursor register and a small sequencer
// that drives one shared sweep counter for clears and scrolls.
// ---------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------------
//  in      | in_valid / in_stall   | func, char_code, cell_index
//  out     | out_valid / out_stall | cursor_pos, cursor_written, scrolled, cell_data
//  cfg     | cfg_we                | cfg_data (text attribute byte)
//
//  Plain items (put, backspace, newline, read, unused code) take the accept
//  cycle and then the result cycle. A scroll adds a read and a write per copied
//  cell, then one blank a cycle for the last row; a clear adds a blank fill of
//  every cell. After reset a clearing pass that zeroes every cell holds in_stall
//  high. out_stall holds the result; the next item is taken meanwhile, and the
//  block waits in its result cycle only if the output register is still full.
//
`default_nettype none

module text_console_scroll_engine #(
  parameter int COLUMNS   = tcse_pkg::DEF_COLUMNS,
  parameter int ROW_COUNT = tcse_pkg::DEF_ROW_COUNT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [tcse_pkg::ATTR_W-1:0]   cfg_data,
  // input items
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tcse_pkg::FUNC_W-1:0]   func,
  input  wire logic [tcse_pkg::CHAR_W-1:0]   char_code,
  input  wire logic [tcse_pkg::INDEX_W-1:0]  cell_index,
  // result items
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [tcse_pkg::CURSOR_W-1:0] cursor_pos,
  output logic                               cursor_written,
  output logic                               scrolled,
  output logic      [tcse_pkg::CELL_W-1:0]   cell_data
);
  import tcse_pkg::*;

  localparam int CELL_TOTAL = COLUMNS * ROW_COUNT;
  localparam int ADDR_W     = $clog2(CELL_TOTAL);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROW_COUNT);
  localparam int CMP_W      = ((INDEX_W > ADDR_W) ? INDEX_W : ADDR_W) + 1;

  typedef enum logic [5:0] {
    S_INIT    = 6'b000001,  // zeroing pass after reset
    S_IDLE    = 6'b000010,  // ready for an item
    S_COPY_RD = 6'b000100,  // scroll: read the cell one row down
    S_COPY_WR = 6'b001000,  // scroll: write it one row up
    S_FILL    = 6'b010000,  // blank fill (clear, or last row of a scroll)
    S_DONE    = 6'b100000   // hand the result to the output register
  } state_t;

  state_t state, state_next;

  // configuration
  logic [ATTR_W-1:0] text_attribute;

  // text cursor and hardware cursor register
  logic [COL_W-1:0]    col, col_next;
  logic [ROW_W-1:0]    row, row_next;
  logic [CURSOR_W-1:0] hw_cursor, hw_cursor_next;

  // item captured at accept
  logic [FUNC_W-1:0] func_q;
  logic [ADDR_W-1:0] idx_q;
  logic              idx_ok_q;
  logic              written_q;
  logic              scrolled_q;

  // accept-cycle decode
  logic              accept;
  logic              advance_row;
  logic              hit_scroll;
  logic              hit_written;
  logic              put_write;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] pos_next;
  logic              idx_ok;

  // memory ports
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  // sweep unit
  sweep_cmd_t        sweep_cmd;
  sweep_stat_t       sweep_stat;
  logic [ADDR_W-1:0] sweep_cnt;
  logic [ADDR_W-1:0] sweep_src;

  // output register
  logic out_free;
  logic out_load;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == S_DONE) && out_free;

  assign cur_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  assign idx_ok   = CMP_W'(cell_index) < CMP_W'(CELL_TOTAL);

  // ---- cursor update for the item being accepted ----
  always_comb begin
    col_next    = col;
    row_next    = row;
    advance_row = 1'b0;
    hit_scroll  = 1'b0;
    hit_written = 1'b0;
    put_write   = 1'b0;
    case (func)
      FUNC_PUT: begin
        if (char_code == KEY_NEWLINE) begin
          col_next    = '0;
          advance_row = 1'b1;
        end else if (char_code == KEY_BACKSPACE) begin
          // left, stopping at column 0
          col_next    = (col == '0) ? col : col - COL_W'(1);
          hit_written = 1'b1;
        end else begin
          put_write   = 1'b1;
          hit_written = 1'b1;
          if (col == COL_W'(COLUMNS - 1)) begin
            col_next    = '0;
            advance_row = 1'b1;
          end else begin
            col_next = col + COL_W'(1);
          end
        end
      end
      FUNC_CLEAR: begin
        col_next    = '0;
        row_next    = '0;
        hit_written = 1'b1;
      end
      default: begin
      end
    endcase
    // past the last row: scroll and stay on the last row
    if (advance_row) begin
      if (row == ROW_W'(ROW_COUNT - 1)) begin
        hit_scroll = 1'b1;
      end else begin
        row_next = row + ROW_W'(1);
      end
    end
  end

  assign pos_next       = ADDR_W'(row_next) * ADDR_W'(COLUMNS) + ADDR_W'(col_next);
  assign hw_cursor_next = hit_written ? CURSOR_W'(pos_next) : hw_cursor;

  // ---- sequencer ----
  always_comb begin
    state_next     = state;
    sweep_cmd.step = 1'b0;
    sweep_cmd.wrap = 1'b0;
    case (state)
      S_INIT: begin
        sweep_cmd.step = 1'b1;
        sweep_cmd.wrap = sweep_stat.fill_last;
        if (sweep_stat.fill_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (hit_scroll) begin
            state_next = S_COPY_RD;
          end else if (func == FUNC_CLEAR) begin
            state_next = S_FILL;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_COPY_RD: begin
        state_next = S_COPY_WR;
      end
      S_COPY_WR: begin
        // the counter runs on from the copy into the blank last row
        sweep_cmd.step = 1'b1;
        state_next     = sweep_stat.copy_last ? S_FILL : S_COPY_RD;
      end
      S_FILL: begin
        sweep_cmd.step = 1'b1;
        sweep_cmd.wrap = sweep_stat.fill_last;
        if (sweep_stat.fill_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // ---- memory port selection ----
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_cnt;
    mem_wdata = '0;
    mem_raddr = idx_q;
    case (state)
      S_INIT: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_we    = accept && put_write;
        mem_waddr = cur_addr;
        mem_wdata = {text_attribute, char_code};
        mem_raddr = ADDR_W'(cell_index);
      end
      S_COPY_RD: begin
        mem_raddr = sweep_src;
      end
      S_COPY_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = {text_attribute, BLANK_GLYPH};
      end
      default: begin
      end
    endcase
  end

  tcse_cell_ram #(
    .DEPTH  (CELL_TOTAL),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tcse_sweep_unit #(
    .COLUMNS   (COLUMNS),
    .ROW_COUNT (ROW_COUNT),
    .ADDR_W    (ADDR_W)
  ) u_sweep (
    .clk      (clk),
    .rst      (rst),
    .cmd      (sweep_cmd),
    .cnt      (sweep_cnt),
    .src_addr (sweep_src),
    .stat     (sweep_stat)
  );

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_INIT;
      text_attribute <= ATTR_RESET;
      col            <= '0;
      row            <= '0;
      hw_cursor      <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        text_attribute <= cfg_data;
      end
      if (accept) begin
        col       <= col_next;
        row       <= row_next;
        hw_cursor <= hw_cursor_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q     <= func;
      idx_q      <= ADDR_W'(cell_index);
      idx_ok_q   <= idx_ok;
      written_q  <= hit_written;
      scrolled_q <= hit_scroll;
    end
    // read data is valid in the result cycle; the read address holds there
    if (out_load) begin
      cursor_pos     <= hw_cursor;
      cursor_written <= written_q;
      scrolled       <= scrolled_q;
      cell_data      <= ((func_q == FUNC_READ) && idx_ok_q) ? mem_rdata : '0;
    end
  end

`ifndef SYNTH
  // text cursor always stays on the screen
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    (col <= COL_W'(COLUMNS - 1)) && (row <= ROW_W'(ROW_COUNT - 1)))
    else $error("text cursor off screen");

  // a clear homes the hardware cursor at once
  a_clear_homes: assert property (@(posedge clk) disable iff (rst)
    (accept && (func == FUNC_CLEAR)) |=> (hw_cursor == '0))
    else $error("clear did not home hardware cursor");

  // a result only comes from the result cycle of the sequencer
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result loaded outside result cycle");

  // sweeps always start from the top of the store
  a_sweep_home: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (sweep_cnt == '0))
    else $error("sweep counter not at zero when idle");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench: text console scroll engine
// Drives put, clear, read and spare items through the valid/stall channels,
// mirrors the console state in a shadow screen and checks every result item
// field by field, across several attribute settings and stall patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import tcse_pkg::*;

  localparam int COLUMNS   = DEF_COLUMNS;
  localparam int ROW_COUNT = DEF_ROW_COUNT;
  localparam int CELLS     = COLUMNS * ROW_COUNT;
  localparam int INDEX_MAX = (1 << INDEX_W) - 1;

  // func code 3 has no operation behind it
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 335;
  localparam int SCRIPT_ROWS  = 25;
  localparam int SETTLE_CYCLES = 16;
  // Worst case per item: a full scroll plus gaps and stalls, for every item,
  // on top of the clearing pass after reset; then four times over.
  localparam int ITEM_BUDGET  = 2200;
  localparam int CYCLE_LIMIT  = 4 * (CELLS + ITEM_BUDGET * (2 * CELLS + COLUMNS + 64));

  typedef struct packed {
    logic [FUNC_W-1:0]  fn;
    logic [CHAR_W-1:0]  ch;
    logic [INDEX_W-1:0] idx;
  } console_cmd_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] pos;
    logic                wr;
    logic                scr;
    logic [CELL_W-1:0]   data;
  } console_rsp_t;

  // one row of the directed script: item, repeat count, optional typed result
  typedef struct packed {
    console_cmd_t cmd;
    logic [7:0]   reps;
    logic         typed;
    console_rsp_t want;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [ATTR_W-1:0]   cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [FUNC_W-1:0]   func;
  logic [CHAR_W-1:0]   char_code;
  logic [INDEX_W-1:0]  cell_index;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CURSOR_W-1:0] cursor_pos;
  logic                cursor_written;
  logic                scrolled;
  logic [CELL_W-1:0]   cell_data;

  text_console_scroll_engine #(
    .COLUMNS  (COLUMNS),
    .ROW_COUNT(ROW_COUNT)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .char_code     (char_code),
    .cell_index    (cell_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cursor_pos    (cursor_pos),
    .cursor_written(cursor_written),
    .scrolled      (scrolled),
    .cell_data     (cell_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---- shadow console -----------------------------------------------------
  logic [CELL_W-1:0]   mirror_cells [CELLS];
  int                  mirror_col;
  int                  mirror_row;
  logic [CURSOR_W-1:0] mirror_hw;
  logic [ATTR_W-1:0]   mirror_attr;

  console_rsp_t cursor_status_q [$];   // predicted result items, oldest first
  script_row_t  plan [SCRIPT_ROWS];

  int mismatch_count = 0;
  int items_sent     = 0;
  int scroll_count   = 0;
  int clear_count    = 0;
  int read_count     = 0;
  int cycle_count    = 0;
  int in_gap_pct     = 0;   // chance per cycle that the sender holds back
  int out_stall_pct  = 0;   // chance per cycle that the receiver stalls

  // Row advance shared by newline and line wrap; scrolls past the last row.
  function automatic logic bump_row();
    mirror_row++;
    if (mirror_row < ROW_COUNT) return 1'b0;
    for (int i = 0; i < CELLS - COLUMNS; i++) mirror_cells[i] = mirror_cells[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) mirror_cells[i] = {mirror_attr, BLANK_GLYPH};
    mirror_row = ROW_COUNT - 1;
    scroll_count++;
    return 1'b1;
  endfunction

  // Apply one item to the shadow console and return the result it yields.
  function automatic console_rsp_t advance_console(input console_cmd_t c);
    console_rsp_t r;
    r = '0;
    case (c.fn)
      FUNC_PUT: begin
        if (c.ch == KEY_NEWLINE) begin
          // newline leaves the hardware cursor alone
          mirror_col = 0;
          r.scr = bump_row();
        end else if (c.ch == KEY_BACKSPACE) begin
          if (mirror_col > 0) mirror_col--;
          r.wr = 1'b1;
        end else begin
          mirror_cells[mirror_row * COLUMNS + mirror_col] = {mirror_attr, c.ch};
          mirror_col++;
          if (mirror_col >= COLUMNS) begin
            mirror_col = 0;
            r.scr = bump_row();
          end
          r.wr = 1'b1;
        end
        if (r.wr) mirror_hw = CURSOR_W'(mirror_row * COLUMNS + mirror_col);
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < CELLS; i++) mirror_cells[i] = {mirror_attr, BLANK_GLYPH};
        mirror_col = 0;
        mirror_row = 0;
        mirror_hw  = '0;
        r.wr = 1'b1;
        clear_count++;
      end
      FUNC_READ: begin
        // out-of-range index reads as zero
        if (c.idx < CELLS) r.data = mirror_cells[c.idx];
        read_count++;
      end
      default: ;
    endcase
    r.pos = mirror_hw;
    return r;
  endfunction

  function automatic script_row_t script_entry(
    input logic [FUNC_W-1:0] fn, input logic [CHAR_W-1:0] ch,
    input logic [INDEX_W-1:0] idx, input logic [7:0] reps, input logic typed,
    input logic [CURSOR_W-1:0] pos, input logic wr, input logic scr,
    input logic [CELL_W-1:0] data);
    script_row_t s;
    s.cmd   = '{fn, ch, idx};
    s.reps  = reps;
    s.typed = typed;
    s.want  = '{pos, wr, scr, data};
    return s;
  endfunction

  // ---- sender ---------------------------------------------------------------
  // Present one item, hold it until accepted, then log what it should yield.
  // The first gap assignment lands on the previous item's accept edge, so
  // in_valid gets one assignment per step.
  task automatic send_item(input console_cmd_t c, input logic typed,
                           input console_rsp_t typed_rsp);
    console_rsp_t predicted;
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= c.fn;
    char_code  <= c.ch;
    cell_index <= c.idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = advance_console(c);
    cursor_status_q.push_back(typed ? typed_rsp : predicted);
    items_sent++;
  endtask

  // Hold off until every logged result item has come back, then settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (cursor_status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    mirror_attr  = value;
  endtask

  // Random traffic in bursts: runs of text long enough to wrap lines,
  // newline runs that push into scrolling, reads, a little noise and clears.
  task automatic random_phase(input int count);
    console_cmd_t c;
    int left;
    int pick;
    int burst;
    left = count;
    while (left > 0) begin
      pick = $urandom_range(99);
      if (pick < 40) burst = $urandom_range(100, 1);
      else if (pick < 60) burst = $urandom_range(4, 1);
      else if (pick < 90) burst = $urandom_range(8, 1);
      else burst = 1;
      for (int k = 0; k < burst && left > 0; k++) begin
        // fields an operation ignores still carry random bits
        c.ch  = CHAR_W'($urandom_range(255));
        c.idx = INDEX_W'($urandom_range(INDEX_MAX));
        if (pick < 40) begin
          c.fn = FUNC_PUT;
          if ($urandom_range(19) == 0) c.ch = KEY_BACKSPACE;
          else if (c.ch == KEY_NEWLINE || c.ch == KEY_BACKSPACE) c.ch = c.ch ^ 8'h80;
        end else if (pick < 60) begin
          c.fn = FUNC_PUT;
          c.ch = KEY_NEWLINE;
        end else if (pick < 90) begin
          c.fn  = FUNC_READ;
          c.idx = ($urandom_range(9) == 0) ? INDEX_W'($urandom_range(INDEX_MAX, CELLS))
                                           : INDEX_W'($urandom_range(CELLS - 1));
        end else if (pick < 96) begin
          c.fn = FUNC_W'($urandom_range(3));
        end else begin
          c.fn = FUNC_CLEAR;
        end
        send_item(c, 1'b0, '0);
        left--;
      end
    end
  endtask

  // ---- receiver and checker -------------------------------------------------
  always @(posedge clk) out_stall <= ($urandom_range(99) < out_stall_pct);

  always @(posedge clk) begin
    console_rsp_t want;
    if (!rst && out_valid && !out_stall) begin
      if (cursor_status_q.size() == 0) begin
        $error("result item with nothing outstanding: pos %0d data %h", cursor_pos, cell_data);
        mismatch_count++;
      end else begin
        want = cursor_status_q.pop_front();
        if (cursor_pos !== want.pos) begin
          $error("cursor_pos: expected %0d, got %0d", want.pos, cursor_pos);
          mismatch_count++;
        end
        if (cursor_written !== want.wr) begin
          $error("cursor_written: expected %0d, got %0d", want.wr, cursor_written);
          mismatch_count++;
        end
        if (scrolled !== want.scr) begin
          $error("scrolled: expected %0d, got %0d", want.scr, scrolled);
          mismatch_count++;
        end
        if (cell_data !== want.data) begin
          $error("cell_data: expected %h, got %h", want.data, cell_data);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---- main sequence --------------------------------------------------------
  initial begin
    logic [ATTR_W-1:0] attr_plan [PHASES];
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    func       <= FUNC_PUT;
    char_code  <= '0;
    cell_index <= '0;

    for (int i = 0; i < CELLS; i++) mirror_cells[i] = '0;
    mirror_col  = 0;
    mirror_row  = 0;
    mirror_hw   = '0;
    mirror_attr = ATTR_RESET;

    // Directed script, attribute at its reset value 0x0A. Typed results where
    // obvious; the scroll and wrap rows lean on the shadow console.
    //                       fn          ch             idx      reps typ pos wr sc data
    plan[0]  = script_entry(FUNC_READ,  8'h00,         11'd0,    1, 1, 0,  0, 0, 16'h0000);
    plan[1]  = script_entry(FUNC_READ,  8'h00,         11'd1999, 1, 1, 0,  0, 0, 16'h0000);
    plan[2]  = script_entry(FUNC_READ,  8'hFF,         11'd2047, 1, 1, 0,  0, 0, 16'h0000);
    plan[3]  = script_entry(FUNC_SPARE, 8'hFF,         11'd2047, 1, 1, 0,  0, 0, 16'h0000);
    plan[4]  = script_entry(FUNC_PUT,   8'h41,         11'd0,    1, 1, 1,  1, 0, 16'h0000);
    plan[5]  = script_entry(FUNC_READ,  8'h00,         11'd0,    1, 1, 1,  0, 0, 16'h0A41);
    plan[6]  = script_entry(FUNC_PUT,   KEY_BACKSPACE, 11'd0,    1, 1, 0,  1, 0, 16'h0000);
    // backspace at column zero stays put
    plan[7]  = script_entry(FUNC_PUT,   KEY_BACKSPACE, 11'd0,    1, 1, 0,  1, 0, 16'h0000);
    // top bit of the glyph must not leak into the attribute
    plan[8]  = script_entry(FUNC_PUT,   8'hFF,         11'd0,    1, 1, 1,  1, 0, 16'h0000);
    plan[9]  = script_entry(FUNC_PUT,   8'h00,         11'd0,    1, 1, 2,  1, 0, 16'h0000);
    plan[10] = script_entry(FUNC_READ,  8'h00,         11'd0,    1, 1, 2,  0, 0, 16'h0AFF);
    plan[11] = script_entry(FUNC_READ,  8'h00,         11'd1,    1, 1, 2,  0, 0, 16'h0A00);
    // newline: hardware cursor keeps its old value
    plan[12] = script_entry(FUNC_PUT,   KEY_NEWLINE,   11'd0,    1, 1, 2,  0, 0, 16'h0000);
    plan[13] = script_entry(FUNC_PUT,   8'h80,         11'd0,    1, 1, 81, 1, 0, 16'h0000);
    plan[14] = script_entry(FUNC_READ,  8'h00,         11'd80,   1, 1, 81, 0, 0, 16'h0A80);
    plan[15] = script_entry(FUNC_CLEAR, 8'h00,         11'd0,    1, 1, 0,  1, 0, 16'h0000);
    plan[16] = script_entry(FUNC_READ,  8'h00,         11'd1999, 1, 1, 0,  0, 0, 16'h0A20);
    // walk down to the last row, then newline there scrolls
    plan[17] = script_entry(FUNC_PUT,   KEY_NEWLINE,   11'd0,   24, 0, 0,  0, 0, 16'h0000);
    plan[18] = script_entry(FUNC_PUT,   KEY_NEWLINE,   11'd0,    1, 0, 0,  0, 0, 16'h0000);
    plan[19] = script_entry(FUNC_READ,  8'h00,         11'd1920, 1, 0, 0,  0, 0, 16'h0000);
    // fill the last line; the final character wraps and scrolls
    plan[20] = script_entry(FUNC_PUT,   8'h7E,         11'd0,   79, 0, 0,  0, 0, 16'h0000);
    plan[21] = script_entry(FUNC_PUT,   8'h01,         11'd0,    1, 0, 0,  0, 0, 16'h0000);
    plan[22] = script_entry(FUNC_READ,  8'h00,         11'd1840, 1, 0, 0,  0, 0, 16'h0000);
    plan[23] = script_entry(FUNC_READ,  8'h00,         11'd1919, 1, 0, 0,  0, 0, 16'h0000);
    plan[24] = script_entry(FUNC_PUT,   KEY_BACKSPACE, 11'd0,    1, 0, 0,  0, 0, 16'h0000);

    attr_plan[0] = 8'h00;
    attr_plan[1] = 8'hFF;
    attr_plan[2] = ATTR_W'($urandom_range(255));
    attr_plan[3] = 8'h80;
    attr_plan[4] = ATTR_W'($urandom_range(255));
    attr_plan[5] = 8'h7F;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // The block runs its clearing pass here with in_stall high; the first
    // item simply waits for it.
    for (int r = 0; r < SCRIPT_ROWS; r++)
      for (int k = 0; k < plan[r].reps; k++)
        send_item(plan[r].cmd, plan[r].typed, plan[r].want);
    // sender pauses until every result item is back
    drain_results();

    // Stall patterns: sender-light/receiver-heavy, then swapped, then none.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 2)
        0: begin
          in_gap_pct    = 10;
          out_stall_pct = 45;
        end
        1: begin
          in_gap_pct    = 45;
          out_stall_pct = 10;
        end
        default: begin
          in_gap_pct    = 0;
          out_stall_pct = 0;
        end
      endcase
      write_attribute(attr_plan[ph]);
      random_phase(PHASE_ITEMS);
      drain_results();
    end

    $display("covered %0d items: %0d scrolls, %0d clears, %0d cell reads",
             items_sent, scroll_count, clear_count, read_count);
    $display("attribute reset value plus six settings incl. 00 and ff, three stall patterns");
    if (mismatch_count == 0 && cursor_status_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
